### sv/uart_register_block_top_macros.svh
// ----------------------------------------------------------------------------
// uart register block assertion macros
// shared property wrappers, clocked on i_clk and disabled during reset
// ----------------------------------------------------------------------------
`ifndef UART_REGISTER_BLOCK_TOP_MACROS_SVH
`define UART_REGISTER_BLOCK_TOP_MACROS_SVH

// plain property, written in full by the caller
`define UART_RB_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// same-cycle implication
`define UART_RB_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

`endif

### sv/uart_rb_pkg.sv
// ----------------------------------------------------------------------------
// uart register block package
// request and response types, command and status codes, register map and
// byte-lane helper functions
// ----------------------------------------------------------------------------
package uart_rb_pkg;

    localparam int RX_FIFO_DEPTH_DEF = 256;
    localparam int FIFO_DATA_W       = 8;

    // commands
    localparam logic [2:0] CMD_READ      = 3'd0;
    localparam logic [2:0] CMD_WRITE     = 3'd1;
    localparam logic [2:0] CMD_LINE_BYTE = 3'd2;
    localparam logic [2:0] CMD_TX_DONE   = 3'd3;
    localparam logic [2:0] CMD_RX_DONE   = 3'd4;

    // status codes
    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_SET_FLAG  = 3'd1;
    localparam logic [2:0] ST_RD_DIS    = 3'd2;
    localparam logic [2:0] ST_RD_EMPTY  = 3'd3;
    localparam logic [2:0] ST_WR_DIS    = 3'd4;
    localparam logic [2:0] ST_TX_FULL   = 3'd5;
    localparam logic [2:0] ST_BAD_REG   = 3'd6;
    localparam logic [2:0] ST_FIFO_FULL = 3'd7;

    // register map, word index = address bits 9:2
    localparam logic [9:0] ADDR_WORD_MASK = 10'h3fc;
    localparam logic [7:0] REG_SR  = 8'd0;
    localparam logic [7:0] REG_DR  = 8'd1;
    localparam logic [7:0] REG_BRR = 8'd2;
    localparam logic [7:0] REG_CR1 = 8'd3;
    localparam logic [7:0] REG_CR2 = 8'd4;
    localparam logic [7:0] REG_CR3 = 8'd5;

    localparam logic [31:0] DR_MASK  = 32'h0000_01ff;
    localparam logic [31:0] BRR_MASK = 32'h0000_ffff;
    localparam logic [31:0] CR1_MASK = 32'h0000_3fff;
    localparam logic [31:0] CR2_MASK = 32'h0000_7f7f;
    localparam logic [31:0] CR3_MASK = 32'h0000_07ff;

    // status register bits
    localparam int SR_TXE  = 7;
    localparam int SR_TC   = 6;
    localparam int SR_RXNE = 5;

    // control register 1 bits
    localparam int CR1_UE     = 13;
    localparam int CR1_TXEIE  = 7;
    localparam int CR1_TCIE   = 6;
    localparam int CR1_RXNEIE = 5;
    localparam int CR1_TE     = 3;
    localparam int CR1_RE     = 2;

    typedef struct packed {
        logic [2:0]  command;
        logic [9:0]  reg_address;
        logic [2:0]  access_bytes;
        logic [31:0] write_data;
        logic [7:0]  rx_byte;
    } t_req;

    typedef struct packed {
        logic [31:0] read_data;
        logic        tx_valid;
        logic [7:0]  tx_byte;
        logic        rx_timer_start;
        logic        irq;
        logic [2:0]  status;
        logic [8:0]  rx_fifo_level;
    } t_rsp;

    typedef struct packed {
        logic                   push;
        logic                   pop;
        logic [FIFO_DATA_W-1:0] push_data;
    } t_fifo_ctl;

    typedef struct packed {
        logic empty;
        logic full;
    } t_fifo_stat;

    // field mask for an access width, saturating at a full word
    function automatic logic [31:0] lane_mask(input logic [2:0] nbytes);
        logic [31:0] m;
        unique case (nbytes)
            3'd0:    m = 32'h0000_0000;
            3'd1:    m = 32'h0000_00ff;
            3'd2:    m = 32'h0000_ffff;
            3'd3:    m = 32'h00ff_ffff;
            default: m = 32'hffff_ffff;
        endcase
        return m;
    endfunction

    function automatic logic [31:0] lane_merge(input logic [31:0] old_val,
                                               input logic [1:0]  lane,
                                               input logic [2:0]  nbytes,
                                               input logic [31:0] wdata);
        logic [63:0] m;
        logic [63:0] d;
        logic [5:0]  sh;
        sh = {1'b0, lane, 3'b000};
        m  = {32'h0, lane_mask(nbytes)} << sh;
        d  = {32'h0, wdata} << sh;
        return (old_val & ~m[31:0]) | (d[31:0] & m[31:0]);
    endfunction

    function automatic logic [31:0] lane_extract(input logic [31:0] val,
                                                 input logic [1:0]  lane,
                                                 input logic [2:0]  nbytes);
        logic [4:0] sh;
        sh = {lane, 3'b000};
        return (val >> sh) & lane_mask(nbytes);
    endfunction

endpackage

### sv/uart_rb_ram.sv
// ----------------------------------------------------------------------------
// uart register block generic ram
// one write port, one read port with registered read data
// ----------------------------------------------------------------------------
module uart_rb_ram #(
    parameter int WIDTH = uart_rb_pkg::FIFO_DATA_W,
    parameter int DEPTH = uart_rb_pkg::RX_FIFO_DEPTH_DEF
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

### sv/uart_rb_fifo.sv
// ----------------------------------------------------------------------------
// uart register block receive fifo
// head pointer and fill count around the fifo ram; reports next fill level
// ----------------------------------------------------------------------------
`include "uart_register_block_top_macros.svh"

module uart_rb_fifo #(
    parameter int DEPTH = uart_rb_pkg::RX_FIFO_DEPTH_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  uart_rb_pkg::t_fifo_ctl i_ctl,
    output uart_rb_pkg::t_fifo_stat o_stat,
    output logic [uart_rb_pkg::FIFO_DATA_W-1:0] o_rd_data,
    output logic [8:0]             o_level
);

    import uart_rb_pkg::*;

    localparam int IDX_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int SUM_W = IDX_W + 1;

    logic [IDX_W-1:0] r_head;
    logic [IDX_W-1:0] n_head;
    logic [CNT_W-1:0] r_count;
    logic [CNT_W-1:0] n_count;
    logic [SUM_W-1:0] tail_sum;
    logic [SUM_W-1:0] tail_wrap;
    logic [IDX_W-1:0] tail;

    always_comb begin
        tail_sum  = SUM_W'(r_head) + SUM_W'(r_count);
        tail_wrap = (tail_sum >= SUM_W'(DEPTH)) ? tail_sum - SUM_W'(DEPTH) : tail_sum;
        tail      = tail_wrap[IDX_W-1:0];

        n_head = r_head;
        if (i_ctl.pop) begin
            n_head = (r_head == IDX_W'(DEPTH - 1)) ? '0 : r_head + IDX_W'(1);
        end
        n_count = r_count + CNT_W'(i_ctl.push) - CNT_W'(i_ctl.pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head  <= '0;
            r_count <= '0;
        end else begin
            r_head  <= n_head;
            r_count <= n_count;
        end
    end

    uart_rb_ram #(
        .WIDTH (FIFO_DATA_W),
        .DEPTH (DEPTH)
    ) u_ram (
        .i_clk     (i_clk),
        .i_wr_en   (i_ctl.push),
        .i_wr_addr (tail),
        .i_wr_data (i_ctl.push_data),
        .i_rd_en   (i_ctl.pop),
        .i_rd_addr (r_head),
        .o_rd_data (o_rd_data)
    );

    assign o_stat.empty = (r_count == '0);
    assign o_stat.full  = (r_count == CNT_W'(DEPTH));
    assign o_level      = 9'(n_count);

    `UART_RB_ASSERT_IMPL(a_no_push_when_full, i_ctl.push, !o_stat.full, "push into full fifo")
    `UART_RB_ASSERT_IMPL(a_pop_has_data, i_ctl.pop, !o_stat.empty || i_ctl.push, "pop from empty fifo")
    `UART_RB_ASSERT(a_count_in_range, r_count <= CNT_W'(DEPTH), "fifo count above depth")

endmodule

### sv/uart_rb_regs.sv
// ----------------------------------------------------------------------------
// uart register block register file
// status flags, data, baud and control registers; decodes one request per
// cycle while i_go is high and drives the receive fifo
// ----------------------------------------------------------------------------
module uart_rb_regs (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_go,
    input  uart_rb_pkg::t_req       i_req,
    input  uart_rb_pkg::t_fifo_stat i_fifo_stat,
    input  logic [uart_rb_pkg::FIFO_DATA_W-1:0] i_fifo_rd_data,
    input  logic [8:0]              i_fifo_level,
    output uart_rb_pkg::t_fifo_ctl  o_fifo_ctl,
    output uart_rb_pkg::t_rsp       o_rsp
);

    import uart_rb_pkg::*;

    logic        r_txe,  n_txe;
    logic        r_tc,   n_tc;
    logic        r_rxne, n_rxne;
    logic [7:0]  r_rx_data, n_rx_data;
    logic        r_rx_pend, n_rx_pend;
    logic [7:0]  r_tx_hold, n_tx_hold;
    logic [15:0] r_brr,  n_brr;
    logic [13:0] r_cr1,  n_cr1;
    logic [14:0] r_cr2,  n_cr2;
    logic [10:0] r_cr3,  n_cr3;
    logic        r_rx_busy, n_rx_busy;

    logic [7:0]  rx_cur;
    logic        rx_en;
    logic        tx_en;
    logic [1:0]  lane;
    logic [2:0]  nbytes;
    logic [7:0]  reg_idx;
    logic [31:0] sr_val;
    logic [31:0] merged;
    logic [31:0] rd;
    logic [2:0]  status;
    logic        tx_valid;
    logic [7:0]  tx_byte;
    logic        svc;
    logic        push;
    logic        pop;

    always_comb begin
        rx_cur  = r_rx_pend ? i_fifo_rd_data : r_rx_data;
        rx_en   = r_cr1[CR1_UE] & r_cr1[CR1_RE];
        tx_en   = r_cr1[CR1_UE] & r_cr1[CR1_TE];
        lane    = i_req.reg_address[1:0];
        nbytes  = i_req.access_bytes;
        reg_idx = 8'((i_req.reg_address & ADDR_WORD_MASK) >> 2);
        sr_val  = {24'h0, r_txe, r_tc, r_rxne, 5'h0};

        n_txe     = r_txe;
        n_tc      = r_tc;
        n_rxne    = r_rxne;
        n_rx_data = rx_cur;
        n_rx_pend = 1'b0;
        n_tx_hold = r_tx_hold;
        n_brr     = r_brr;
        n_cr1     = r_cr1;
        n_cr2     = r_cr2;
        n_cr3     = r_cr3;
        n_rx_busy = r_rx_busy;

        merged   = '0;
        rd       = '0;
        status   = ST_OK;
        tx_valid = 1'b0;
        tx_byte  = '0;
        svc      = 1'b0;
        push     = 1'b0;

        unique case (i_req.command)
            CMD_READ: begin
                unique case (reg_idx)
                    REG_SR:  rd = lane_extract(sr_val, lane, nbytes);
                    REG_DR: begin
                        if (!rx_en) begin
                            status = ST_RD_DIS;
                        end else if (r_rxne) begin
                            rd     = lane_extract({24'h0, rx_cur}, lane, nbytes);
                            n_rxne = 1'b0;
                            svc    = 1'b1;
                        end else begin
                            status = ST_RD_EMPTY;
                        end
                    end
                    REG_BRR: rd = lane_extract({16'h0, r_brr}, lane, nbytes);
                    REG_CR1: rd = lane_extract({18'h0, r_cr1}, lane, nbytes);
                    REG_CR2: rd = lane_extract({17'h0, r_cr2}, lane, nbytes);
                    REG_CR3: rd = lane_extract({21'h0, r_cr3}, lane, nbytes);
                    default: status = ST_BAD_REG;
                endcase
            end
            CMD_WRITE: begin
                unique case (reg_idx)
                    REG_SR: begin
                        merged = lane_merge(sr_val, lane, nbytes, i_req.write_data);
                        if (merged[SR_TC] || merged[SR_RXNE]) begin
                            status = ST_SET_FLAG;
                        end else begin
                            n_tc   = 1'b0;
                            n_rxne = 1'b0;
                        end
                    end
                    REG_DR: begin
                        merged = lane_merge(32'h0, lane, nbytes, i_req.write_data) & DR_MASK;
                        priority if (!tx_en) begin
                            status = ST_WR_DIS;
                        end else if (r_tc) begin
                            n_tc     = 1'b0;
                            tx_valid = 1'b1;
                            tx_byte  = merged[7:0];
                        end else if (r_txe) begin
                            n_tx_hold = merged[7:0];
                            n_txe     = 1'b0;
                        end else begin
                            status = ST_TX_FULL;
                        end
                    end
                    REG_BRR: begin
                        merged = lane_merge({16'h0, r_brr}, lane, nbytes, i_req.write_data);
                        n_brr  = 16'(merged & BRR_MASK);
                    end
                    REG_CR1: begin
                        merged = lane_merge({18'h0, r_cr1}, lane, nbytes, i_req.write_data);
                        n_cr1  = 14'(merged & CR1_MASK);
                    end
                    REG_CR2: begin
                        merged = lane_merge({17'h0, r_cr2}, lane, nbytes, i_req.write_data);
                        n_cr2  = 15'(merged & CR2_MASK);
                    end
                    REG_CR3: begin
                        merged = lane_merge({21'h0, r_cr3}, lane, nbytes, i_req.write_data);
                        n_cr3  = 11'(merged & CR3_MASK);
                    end
                    default: status = ST_BAD_REG;
                endcase
            end
            CMD_LINE_BYTE: begin
                if (i_fifo_stat.full) begin
                    status = ST_FIFO_FULL;
                end else begin
                    push = 1'b1;
                    svc  = 1'b1;
                end
            end
            CMD_TX_DONE: begin
                if (r_txe) begin
                    n_tc = 1'b1;
                end else begin
                    n_txe    = 1'b1;
                    n_tc     = 1'b0;
                    tx_valid = 1'b1;
                    tx_byte  = r_tx_hold;
                end
            end
            CMD_RX_DONE: begin
                n_rx_busy = 1'b0;
                svc       = 1'b1;
            end
            default: ;
        endcase

        // fifo service
        pop = i_go & svc & (push | !i_fifo_stat.empty) & !n_rx_busy & !(rx_en & n_rxne);
        if (pop) begin
            n_rx_busy = 1'b1;
            if (rx_en) begin
                n_rxne = 1'b1;
                if (i_fifo_stat.empty) begin
                    n_rx_data = i_req.rx_byte;
                end else begin
                    n_rx_pend = 1'b1;
                end
            end
        end

        o_fifo_ctl.push      = i_go & push;
        o_fifo_ctl.pop       = pop;
        o_fifo_ctl.push_data = i_req.rx_byte;

        o_rsp.read_data      = rd;
        o_rsp.tx_valid       = tx_valid;
        o_rsp.tx_byte        = tx_byte;
        o_rsp.rx_timer_start = pop;
        o_rsp.irq            = (n_cr1[CR1_TCIE] & n_tc) | (n_cr1[CR1_TXEIE] & n_txe)
                             | (n_cr1[CR1_RXNEIE] & n_rxne);
        o_rsp.status         = status;
        o_rsp.rx_fifo_level  = i_fifo_level;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_txe     <= 1'b1;
            r_tc      <= 1'b1;
            r_rxne    <= 1'b0;
            r_brr     <= '0;
            r_cr1     <= '0;
            r_cr2     <= '0;
            r_cr3     <= '0;
            r_rx_busy <= 1'b0;
            r_rx_pend <= 1'b0;
        end else begin
            r_rx_pend <= n_rx_pend;
            if (i_go) begin
                r_txe     <= n_txe;
                r_tc      <= n_tc;
                r_rxne    <= n_rxne;
                r_brr     <= n_brr;
                r_cr1     <= n_cr1;
                r_cr2     <= n_cr2;
                r_cr3     <= n_cr3;
                r_rx_busy <= n_rx_busy;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_rx_data <= n_rx_data;
        if (i_go) begin
            r_tx_hold <= n_tx_hold;
        end
    end

endmodule

### sv/uart_register_block_top.sv
// ----------------------------------------------------------------------------
// uart register block top level
// Takes one request per clock while o_req_stall is low: a bus read or write, a
// received line byte, or the end of a transmit or receive character time. A
// request is captured in an input register, then decoded and applied to the
// registers and the receive fifo; its response is written into the result
// register at the same edge as the register update, or into the second entry
// if the result register is held by i_rsp_stall. A two-entry result buffer
// lets the block keep accepting while one response waits. The receive fifo
// (RX_FIFO_DEPTH bytes) lives in a ram with registered read and is tracked by
// a fill count, so no clearing pass is needed after reset.
// ----------------------------------------------------------------------------
`include "uart_register_block_top_macros.svh"

module uart_register_block_top #(
    parameter int RX_FIFO_DEPTH = uart_rb_pkg::RX_FIFO_DEPTH_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_req_valid,
    output logic              o_req_stall,
    input  uart_rb_pkg::t_req i_req,
    output logic              o_rsp_valid,
    input  logic              i_rsp_stall,
    output uart_rb_pkg::t_rsp o_rsp
);

    import uart_rb_pkg::*;

    logic       r_in_valid;
    t_req       r_in_req;
    logic       r_out_valid;
    t_rsp       r_out_rsp;
    logic       r_skid_valid;
    t_rsp       r_skid_rsp;

    logic       go;
    t_rsp       core_rsp;
    t_fifo_ctl  fifo_ctl;
    t_fifo_stat fifo_stat;
    logic [FIFO_DATA_W-1:0] fifo_rd_data;
    logic [8:0] fifo_level;

    assign go          = r_in_valid & !r_skid_valid;
    assign o_req_stall = r_in_valid & r_skid_valid;

    uart_rb_regs u_regs (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_go           (go),
        .i_req          (r_in_req),
        .i_fifo_stat    (fifo_stat),
        .i_fifo_rd_data (fifo_rd_data),
        .i_fifo_level   (fifo_level),
        .o_fifo_ctl     (fifo_ctl),
        .o_rsp          (core_rsp)
    );

    uart_rb_fifo #(
        .DEPTH (RX_FIFO_DEPTH)
    ) u_fifo (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_ctl     (fifo_ctl),
        .o_stat    (fifo_stat),
        .o_rd_data (fifo_rd_data),
        .o_level   (fifo_level)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid   <= 1'b0;
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            if (!o_req_stall) begin
                r_in_valid <= i_req_valid;
            end
            if (!r_out_valid || !i_rsp_stall) begin
                if (r_skid_valid) begin
                    r_out_valid  <= 1'b1;
                    r_skid_valid <= 1'b0;
                end else begin
                    r_out_valid <= go;
                end
            end else if (go) begin
                r_skid_valid <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!o_req_stall) begin
            r_in_req <= i_req;
        end
        if (!r_out_valid || !i_rsp_stall) begin
            r_out_rsp <= r_skid_valid ? r_skid_rsp : core_rsp;
        end else if (go) begin
            r_skid_rsp <= core_rsp;
        end
    end

    assign o_rsp_valid = r_out_valid;
    assign o_rsp       = r_out_rsp;

    `UART_RB_ASSERT_IMPL(a_skid_needs_out, r_skid_valid, r_out_valid, "skid entry without result")
    `UART_RB_ASSERT(a_held_goes_to_skid, (go && r_out_valid && i_rsp_stall) |=> r_skid_valid, "response lost while result held")
    `UART_RB_ASSERT(a_drain_empties, (r_out_valid && !i_rsp_stall && !r_skid_valid && !go) |=> !r_out_valid, "response repeated after drain")

endmodule

### tb/tb_uart_register_block_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// uart register block testbench
// Drives bus reads and writes, line bytes and character-time events through
// the request channel. A behavioral copy of the usart registers and receive
// fifo predicts each response, which is checked field by field in order.
// Requests idle and responses stall at random, with one stretch of full rate.
// ----------------------------------------------------------------------------
module tb_uart_register_block_top;
    import uart_rb_pkg::*;

    localparam int FIFO_DEPTH = RX_FIFO_DEPTH_DEF;
    localparam logic [7:0] REG_GTPR = 8'd6;
    localparam logic [31:0] CR1_RUN = (32'h1 << CR1_UE) | (32'h1 << CR1_TE) | (32'h1 << CR1_RE);
    localparam logic [31:0] CR1_IRQS = (32'h1 << CR1_TXEIE) | (32'h1 << CR1_TCIE)
                                     | (32'h1 << CR1_RXNEIE);

    logic i_clk = 1'b0;
    logic i_rst_n;
    logic i_req_valid;
    logic o_req_stall;
    t_req i_req;
    logic o_rsp_valid;
    logic i_rsp_stall = 1'b0;
    t_rsp o_rsp;

    bit   no_gaps;
    int   mismatch_count = 0;
    t_rsp usart_rsp_q[$];

    // predicted usart state
    logic        m_txe, m_tc, m_rxne, m_rx_busy, m_irq;
    logic [7:0]  m_rdr;
    logic [8:0]  m_tdr;
    logic [31:0] m_brr, m_cr1, m_cr2, m_cr3;
    logic [7:0]  m_fifo [FIFO_DEPTH];
    int          m_head, m_count;

    uart_register_block_top dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_req_valid),
        .o_req_stall (o_req_stall),
        .i_req       (i_req),
        .o_rsp_valid (o_rsp_valid),
        .i_rsp_stall (i_rsp_stall),
        .o_rsp       (o_rsp)
    );

    always #4 i_clk = ~i_clk;

    always @(negedge i_clk) begin
        i_rsp_stall <= !no_gaps && ($urandom_range(99) < 25);
    end

    function automatic void usart_reset();
        m_txe = 1'b1;
        m_tc = 1'b1;
        m_rxne = 1'b0;
        m_rx_busy = 1'b0;
        m_irq = 1'b0;
        m_rdr = '0;
        m_tdr = '0;
        m_brr = '0;
        m_cr1 = '0;
        m_cr2 = '0;
        m_cr3 = '0;
        m_head = 0;
        m_count = 0;
    endfunction

    function automatic logic [63:0] lane_bits(input logic [2:0] nbytes);
        if (nbytes >= 3'd4) return 64'hffff_ffff;
        return (64'h1 << {nbytes, 3'b000}) - 64'h1;
    endfunction

    function automatic logic [31:0] lane_write(input logic [31:0] old, input logic [1:0] lane,
                                               input logic [2:0] nbytes, input logic [31:0] wd);
        logic [63:0] m;
        logic [63:0] d;
        m = lane_bits(nbytes) << {lane, 3'b000};
        d = {32'h0, wd} << {lane, 3'b000};
        return (old & ~m[31:0]) | (d[31:0] & m[31:0]);
    endfunction

    function automatic logic [31:0] lane_read(input logic [31:0] v, input logic [1:0] lane,
                                              input logic [2:0] nbytes);
        logic [63:0] f;
        f = ({32'h0, v} >> {lane, 3'b000}) & lane_bits(nbytes);
        return f[31:0];
    endfunction

    function automatic logic [31:0] sr_bits();
        logic [31:0] v;
        v = '0;
        v[SR_TXE] = m_txe;
        v[SR_TC] = m_tc;
        v[SR_RXNE] = m_rxne;
        return v;
    endfunction

    // move one byte from the fifo toward the data register, returns timer start
    function automatic logic rx_fifo_service();
        logic en;
        en = m_cr1[CR1_UE] & m_cr1[CR1_RE];
        if (m_count == 0 || m_rx_busy || (en && m_rxne)) return 1'b0;
        if (en) begin
            m_rdr = m_fifo[m_head];
            m_rxne = 1'b1;
        end
        m_head = (m_head + 1) % FIFO_DEPTH;
        m_count--;
        m_rx_busy = 1'b1;
        return 1'b1;
    endfunction

    function automatic t_rsp apply_usart_request(input t_req r);
        t_rsp        e;
        logic [1:0]  lane;
        logic [7:0]  idx;
        logic [31:0] v;
        e = '0;
        e.status = ST_OK;
        lane = r.reg_address[1:0];
        idx = r.reg_address[9:2];
        v = '0;
        case (r.command)
            CMD_READ: begin
                if (idx == REG_SR) v = sr_bits();
                else if (idx == REG_DR) begin
                    if (!m_cr1[CR1_UE] || !m_cr1[CR1_RE]) e.status = ST_RD_DIS;
                    else if (m_rxne) begin
                        v = {24'h0, m_rdr};
                        m_rxne = 1'b0;
                        e.rx_timer_start = rx_fifo_service();
                    end else e.status = ST_RD_EMPTY;
                end
                else if (idx == REG_BRR) v = m_brr;
                else if (idx == REG_CR1) v = m_cr1;
                else if (idx == REG_CR2) v = m_cr2;
                else if (idx == REG_CR3) v = m_cr3;
                else e.status = ST_BAD_REG;
                e.read_data = lane_read(v, lane, r.access_bytes);
            end
            CMD_WRITE: begin
                if (idx == REG_SR) begin
                    v = lane_write(sr_bits(), lane, r.access_bytes, r.write_data);
                    if (v[SR_TC] || v[SR_RXNE]) e.status = ST_SET_FLAG;
                    else begin
                        m_tc = 1'b0;
                        m_rxne = 1'b0;
                    end
                end else if (idx == REG_DR) begin
                    v = lane_write('0, lane, r.access_bytes, r.write_data) & DR_MASK;
                    if (!m_cr1[CR1_UE] || !m_cr1[CR1_TE]) e.status = ST_WR_DIS;
                    else if (m_tc) begin
                        m_tc = 1'b0;
                        e.tx_valid = 1'b1;
                        e.tx_byte = v[7:0];
                    end else if (m_txe) begin
                        m_tdr = v[8:0];
                        m_txe = 1'b0;
                    end else e.status = ST_TX_FULL;
                end
                else if (idx == REG_BRR)
                    m_brr = lane_write(m_brr, lane, r.access_bytes, r.write_data) & BRR_MASK;
                else if (idx == REG_CR1)
                    m_cr1 = lane_write(m_cr1, lane, r.access_bytes, r.write_data) & CR1_MASK;
                else if (idx == REG_CR2)
                    m_cr2 = lane_write(m_cr2, lane, r.access_bytes, r.write_data) & CR2_MASK;
                else if (idx == REG_CR3)
                    m_cr3 = lane_write(m_cr3, lane, r.access_bytes, r.write_data) & CR3_MASK;
                else e.status = ST_BAD_REG;
            end
            CMD_LINE_BYTE: begin
                if (m_count >= FIFO_DEPTH) e.status = ST_FIFO_FULL;
                else begin
                    m_fifo[(m_head + m_count) % FIFO_DEPTH] = r.rx_byte;
                    m_count++;
                    e.rx_timer_start = rx_fifo_service();
                end
            end
            CMD_TX_DONE: begin
                if (m_txe) m_tc = 1'b1;
                else begin
                    m_txe = 1'b1;
                    m_tc = 1'b0;
                    e.tx_valid = 1'b1;
                    e.tx_byte = m_tdr[7:0];
                end
            end
            CMD_RX_DONE: begin
                m_rx_busy = 1'b0;
                e.rx_timer_start = rx_fifo_service();
            end
            default: ;
        endcase
        m_irq = (m_cr1[CR1_TCIE] & m_tc) | (m_cr1[CR1_TXEIE] & m_txe)
              | (m_cr1[CR1_RXNEIE] & m_rxne);
        e.irq = m_irq;
        e.rx_fifo_level = 9'(m_count);
        return e;
    endfunction

    function automatic void check_field(input string name, input logic [31:0] want,
                                        input logic [31:0] got);
        if (got !== want) begin
            $display("%0t ns: %s mismatch, expected 0x%0h, actual 0x%0h",
                     $time, name, want, got);
            mismatch_count++;
        end
    endfunction

    always @(posedge i_clk) begin
        t_rsp want;
        if (i_rst_n && o_rsp_valid && !i_rsp_stall) begin
            if (usart_rsp_q.size() == 0) begin
                $display("%0t ns: response with no request outstanding, expected none, actual 0x%0h",
                         $time, o_rsp);
                mismatch_count++;
            end else begin
                want = usart_rsp_q.pop_front();
                check_field("read_data", want.read_data, o_rsp.read_data);
                check_field("tx_valid", 32'(want.tx_valid), 32'(o_rsp.tx_valid));
                check_field("tx_byte", 32'(want.tx_byte), 32'(o_rsp.tx_byte));
                check_field("rx_timer_start", 32'(want.rx_timer_start),
                            32'(o_rsp.rx_timer_start));
                check_field("irq", 32'(want.irq), 32'(o_rsp.irq));
                check_field("status", 32'(want.status), 32'(o_rsp.status));
                check_field("rx_fifo_level", 32'(want.rx_fifo_level),
                            32'(o_rsp.rx_fifo_level));
            end
        end
    end

    task automatic issue_request(input t_req r);
        @(negedge i_clk);
        while (!no_gaps && $urandom_range(99) < 25) begin
            i_req_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_req_valid <= 1'b1;
        i_req <= r;
        do @(posedge i_clk); while (o_req_stall);
        usart_rsp_q.push_back(apply_usart_request(r));
    endtask

    function automatic t_req bus_req(input logic [2:0] cmd, input logic [7:0] idx,
                                     input logic [1:0] lane, input logic [2:0] nbytes,
                                     input logic [31:0] wdata);
        t_req r;
        r.command = cmd;
        r.reg_address = {idx, lane};
        r.access_bytes = nbytes;
        r.write_data = wdata;
        r.rx_byte = 8'($urandom);
        return r;
    endfunction

    function automatic t_req event_req(input logic [2:0] cmd, input logic [7:0] rxb);
        t_req r;
        r.command = cmd;
        r.reg_address = 10'($urandom);
        r.access_bytes = 3'($urandom);
        r.write_data = $urandom;
        r.rx_byte = rxb;
        return r;
    endfunction

    function automatic logic [2:0] pick_width();
        if ($urandom_range(99) < 85) return $urandom_range(1) ? 3'd2 : 3'd4;
        return 3'($urandom_range(7));
    endfunction

    task automatic test_reset_state();
        issue_request(bus_req(CMD_READ, REG_SR, 2'd0, 3'd4, 32'h0));
        issue_request(bus_req(CMD_READ, REG_CR1, 2'd0, 3'd2, 32'h0));
        issue_request(bus_req(CMD_READ, REG_DR, 2'd0, 3'd4, 32'h0));
        issue_request(bus_req(CMD_WRITE, REG_DR, 2'd0, 3'd4, 32'h0000_01ff));
    endtask

    task automatic test_register_lanes();
        issue_request(bus_req(CMD_WRITE, REG_CR2, 2'd0, 3'd4, 32'hffff_ffff));
        issue_request(bus_req(CMD_READ, REG_CR2, 2'd1, 3'd2, 32'h0));
        issue_request(bus_req(CMD_WRITE, REG_BRR, 2'd1, 3'd7, 32'h0000_00ab));
        issue_request(bus_req(CMD_WRITE, REG_CR3, 2'd0, 3'd0, 32'hffff_ffff));
        issue_request(bus_req(CMD_READ, REG_BRR, 2'd0, 3'd0, 32'h0));
        issue_request(bus_req(CMD_READ, REG_BRR, 2'd1, 3'd3, 32'h0));
        issue_request(bus_req(CMD_WRITE, REG_CR3, 2'd3, 3'd4, 32'hffff_ffff));
    endtask

    task automatic test_bad_access();
        issue_request(bus_req(CMD_READ, REG_GTPR, 2'd0, 3'd4, 32'h0));
        issue_request(bus_req(CMD_WRITE, 8'hff, 2'd3, 3'd4, 32'hffff_ffff));
        issue_request(event_req(3'd5, 8'h00));
        issue_request(event_req(3'd7, 8'hff));
    endtask

    task automatic test_data_paths();
        issue_request(bus_req(CMD_WRITE, REG_CR1, 2'd0, 3'd2, CR1_RUN | CR1_IRQS));
        issue_request(bus_req(CMD_READ, REG_DR, 2'd0, 3'd4, 32'h0));
        issue_request(bus_req(CMD_WRITE, REG_DR, 2'd0, 3'd4, 32'hffff_ffff));
        issue_request(bus_req(CMD_WRITE, REG_DR, 2'd0, 3'd2, 32'h0000_00a5));
        issue_request(bus_req(CMD_WRITE, REG_DR, 2'd0, 3'd2, 32'h0000_003c));
        issue_request(event_req(CMD_TX_DONE, 8'h00));
        issue_request(event_req(CMD_TX_DONE, 8'h00));
        issue_request(bus_req(CMD_WRITE, REG_SR, 2'd0, 3'd4, 32'h0000_00ff));
        issue_request(bus_req(CMD_WRITE, REG_SR, 2'd0, 3'd4, 32'h0));
        issue_request(event_req(CMD_LINE_BYTE, 8'h00));
        issue_request(event_req(CMD_LINE_BYTE, 8'hff));
        issue_request(bus_req(CMD_READ, REG_DR, 2'd0, 3'd4, 32'h0));
        issue_request(event_req(CMD_RX_DONE, 8'h00));
        issue_request(event_req(CMD_RX_DONE, 8'h00));
        issue_request(bus_req(CMD_READ, REG_DR, 2'd0, 3'd4, 32'h0));
    endtask

    task automatic test_rx_fifo_full();
        int guard;
        int pick;
        issue_request(bus_req(CMD_WRITE, REG_CR1, 2'd0, 3'd2, CR1_RUN));
        repeat (FIFO_DEPTH + 3) issue_request(event_req(CMD_LINE_BYTE, 8'($urandom)));
        guard = 0;
        while ((m_count != 0 || m_rxne) && guard < 48) begin
            pick = $urandom_range(99);
            if (pick < 5)
                issue_request(bus_req(CMD_WRITE, REG_CR1, 2'd0, 3'd2, CR1_RUN));
            else if (pick < 10)
                issue_request(bus_req(CMD_WRITE, REG_CR1, 2'd0, 3'd2,
                                      CR1_RUN & ~(32'h1 << CR1_RE)));
            else if (pick < 65)
                issue_request(event_req(CMD_RX_DONE, 8'($urandom)));
            else
                issue_request(bus_req(CMD_READ, REG_DR, 2'd0, pick_width(), $urandom));
            guard++;
        end
    endtask

    task automatic test_random_traffic();
        int          pick;
        logic [1:0]  lane;
        logic [31:0] wd;
        for (int i = 0; i < 120; i++) begin
            no_gaps = (i >= 30 && i < 90);
            pick = $urandom_range(99);
            lane = ($urandom_range(9) == 0) ? 2'($urandom) : 2'd0;
            wd = $urandom;
            if (pick < 14)
                issue_request(event_req(CMD_LINE_BYTE, 8'($urandom)));
            else if (pick < 26)
                issue_request(event_req(CMD_TX_DONE, 8'($urandom)));
            else if (pick < 38)
                issue_request(event_req(CMD_RX_DONE, 8'($urandom)));
            else if (pick < 50)
                issue_request(bus_req(CMD_READ, REG_DR, lane, pick_width(), wd));
            else if (pick < 63)
                issue_request(bus_req(CMD_WRITE, REG_DR, lane, pick_width(), wd));
            else if (pick < 73)
                issue_request(bus_req(CMD_READ, 8'($urandom_range(5)), 2'($urandom),
                                      pick_width(), wd));
            else if (pick < 79) begin
                if ($urandom_range(99) < 80) wd = wd | CR1_RUN;
                issue_request(bus_req(CMD_WRITE, REG_CR1, lane, pick_width(), wd));
            end else if (pick < 85) begin
                case ($urandom_range(2))
                    0: issue_request(bus_req(CMD_WRITE, REG_BRR, 2'($urandom), pick_width(), wd));
                    1: issue_request(bus_req(CMD_WRITE, REG_CR2, 2'($urandom), pick_width(), wd));
                    default:
                        issue_request(bus_req(CMD_WRITE, REG_CR3, 2'($urandom), pick_width(), wd));
                endcase
            end else if (pick < 91) begin
                if ($urandom_range(99) < 60) wd = wd & ~((32'h1 << SR_TC) | (32'h1 << SR_RXNE));
                issue_request(bus_req(CMD_WRITE, REG_SR, lane, pick_width(), wd));
            end else if (pick < 96)
                issue_request(bus_req($urandom_range(1) ? CMD_WRITE : CMD_READ,
                                      8'($urandom_range(255, 6)), 2'($urandom),
                                      pick_width(), wd));
            else
                issue_request(event_req(3'($urandom_range(7, 5)), 8'($urandom)));
        end
        no_gaps = 1'b0;
    endtask

    initial begin
        i_rst_n = 1'b0;
        i_req_valid = 1'b0;
        i_req = '0;
        no_gaps = 1'b0;
        usart_reset();
        repeat (7) @(negedge i_clk);
        i_rst_n <= 1'b1;
        test_reset_state();
        test_register_lanes();
        test_bad_access();
        test_data_paths();
        test_rx_fifo_full();
        test_random_traffic();
        @(negedge i_clk);
        i_req_valid <= 1'b0;
        while (usart_rsp_q.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
        if (mismatch_count == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

    initial begin
        #(5_000_000);
        $display("TEST FAILED");
        $finish;
    end

endmodule

### filelist.f
+incdir+sv
sv/uart_rb_pkg.sv
sv/uart_rb_ram.sv
sv/uart_rb_fifo.sv
sv/uart_rb_regs.sv
sv/uart_register_block_top.sv
tb/tb_uart_register_block_top.sv
